>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the variable header parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is held
`define MVHP_ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// plain condition checked at every clock edge
`define MVHP_ASSERT_NOW(label, expr, msg) `MVHP_ASSERT_PROP(label, (expr), msg)

`endif

>>> src/mvhp_pkg.sv
// ----------------------------------------------------------------------------
// mvhp_pkg
// types and codes shared by the variable header parser modules
// ----------------------------------------------------------------------------
package mvhp_pkg;

    // request kinds
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    // control packet types
    localparam logic [3:0] PT_CONNECT    = 4'd1;
    localparam logic [3:0] PT_CONNACK    = 4'd2;
    localparam logic [3:0] PT_PUBLISH    = 4'd3;
    localparam logic [3:0] PT_SUBSCRIBE  = 4'd8;
    localparam logic [3:0] PT_PINGREQ    = 4'd12;
    localparam logic [3:0] PT_DISCONNECT = 4'd14;

    // result status
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_NEG_PAYLOAD = 2'd2;
    localparam logic [1:0] ST_STRAY       = 2'd3;

    // field codes
    localparam logic [4:0] FC_HEADER   = 5'd0;
    localparam logic [4:0] FC_C_NAME   = 5'd1;
    localparam logic [4:0] FC_C_VER    = 5'd2;
    localparam logic [4:0] FC_C_FLAGS  = 5'd3;
    localparam logic [4:0] FC_C_KEEP   = 5'd4;
    localparam logic [4:0] FC_C_ID     = 5'd5;
    localparam logic [4:0] FC_C_WTOPIC = 5'd6;
    localparam logic [4:0] FC_C_WMSG   = 5'd7;
    localparam logic [4:0] FC_C_USER   = 5'd8;
    localparam logic [4:0] FC_C_PASS   = 5'd9;
    localparam logic [4:0] FC_CA_FLAGS = 5'd10;
    localparam logic [4:0] FC_CA_RC    = 5'd11;
    localparam logic [4:0] FC_P_TOPIC  = 5'd12;
    localparam logic [4:0] FC_P_ID     = 5'd13;
    localparam logic [4:0] FC_P_PAY    = 5'd14;
    localparam logic [4:0] FC_S_ID     = 5'd15;
    localparam logic [4:0] FC_S_TOPIC  = 5'd16;
    localparam logic [4:0] FC_S_QOS    = 5'd17;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [3:0]  packet_type;
        logic [1:0]  qos_level;
        logic [27:0] rem_len;
    } mvhp_req_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic        is_length_byte;
        logic [7:0]  byte_value;
        logic [15:0] word_value;
        logic        field_last;
        logic        packet_done;
        logic [1:0]  status;
    } mvhp_res_t;

    typedef enum logic [25:0] {
        PH_IDLE        = 26'h0000001,
        PH_C_NAME_LEN  = 26'h0000002,
        PH_C_NAME      = 26'h0000004,
        PH_C_VER       = 26'h0000008,
        PH_C_FLAGS     = 26'h0000010,
        PH_C_KEEP      = 26'h0000020,
        PH_C_ID_LEN    = 26'h0000040,
        PH_C_ID        = 26'h0000080,
        PH_C_WT_LEN    = 26'h0000100,
        PH_C_WT        = 26'h0000200,
        PH_C_WM_LEN    = 26'h0000400,
        PH_C_WM        = 26'h0000800,
        PH_C_USER_LEN  = 26'h0001000,
        PH_C_USER      = 26'h0002000,
        PH_C_PASS_LEN  = 26'h0004000,
        PH_C_PASS      = 26'h0008000,
        PH_CA_FLAGS    = 26'h0010000,
        PH_CA_RC       = 26'h0020000,
        PH_P_TOPIC_LEN = 26'h0040000,
        PH_P_TOPIC     = 26'h0080000,
        PH_P_ID        = 26'h0100000,
        PH_P_PAY       = 26'h0200000,
        PH_S_ID        = 26'h0400000,
        PH_S_TOPIC_LEN = 26'h0800000,
        PH_S_TOPIC     = 26'h1000000,
        PH_S_QOS       = 26'h2000000
    } phase_t;

endpackage

>>> src/mqtt_variable_header_parser.sv
// ----------------------------------------------------------------------------
// mqtt_variable_header_parser
// tags each byte after an mqtt fixed header with its variable header field
// ----------------------------------------------------------------------------
//  channel   dir  ports                      carries
//  request   in   s_valid s_ready s_req      header start or one data byte
//  result    out  m_valid m_ready m_res      field tag, values, done, status
//
//  one request per cycle sustained while results are taken; input register then
//  result register, parse state updated as a request moves between them
//  each request gives exactly one result
//  aresetn is synchronous; it empties both registers and returns to idle
//  a stalled result holds the result register; one more request waits in
//  the input register before s_ready drops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqtt_variable_header_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mvhp_pkg::mvhp_req_t s_req,
    output logic                m_valid,
    input  logic                m_ready,
    output mvhp_pkg::mvhp_res_t m_res
);
    import mvhp_pkg::*;

    logic      item_valid;
    logic      item_take;
    mvhp_req_t item;

    mvhp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mvhp_parse_core u_parse_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    // backpressure only when both registers are full and the result stalls
    `MVHP_ASSERT_PROP(a_stall_only_when_full, !s_ready |-> (m_valid && !m_ready), "input stalled while pipeline not full")
    `MVHP_ASSERT_NOW(a_unsup_not_done, !(m_valid && m_res.status == ST_UNSUPPORTED) || !m_res.packet_done, "unsupported type flagged as done")
    `MVHP_ASSERT_NOW(a_stray_shape, !(m_valid && m_res.status == ST_STRAY) || (m_res.field_code == FC_HEADER && !m_res.field_last && !m_res.packet_done), "stray byte result malformed")
    `MVHP_ASSERT_NOW(a_neg_on_topic_len, !(m_valid && m_res.status == ST_NEG_PAYLOAD) || (m_res.field_code == FC_P_TOPIC && m_res.is_length_byte && m_res.packet_done), "negative payload outside topic length")

endmodule

>>> src/mvhp_in_stage.sv
// ----------------------------------------------------------------------------
// mvhp_in_stage
// input register: holds one accepted request until the parser takes it
// ----------------------------------------------------------------------------
module mvhp_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mvhp_pkg::mvhp_req_t s_req,
    output logic               item_valid,
    output mvhp_pkg::mvhp_req_t item,
    input  logic               item_take
);
    import mvhp_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    mvhp_req_t item_reg;

    assign s_ready    = !vld_reg || item_take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (item_take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_req;
        end
    end

endmodule

>>> src/mvhp_parse_core.sv
// ----------------------------------------------------------------------------
// mvhp_parse_core
// parse state, per-byte field decode and the result register
// ----------------------------------------------------------------------------
module mvhp_parse_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  mvhp_pkg::mvhp_req_t item,
    output logic               item_take,
    output logic               m_valid,
    input  logic               m_ready,
    output mvhp_pkg::mvhp_res_t m_res
);
    import mvhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic        has_id_reg, has_id_next;
    logic        idx_reg, idx_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] fleft_reg, fleft_next;
    logic [27:0] pay_reg, pay_next;
    logic        m_valid_reg;
    mvhp_res_t   res_reg, res_next;

    // field that follows a finished one, absent optional fields skipped
    function automatic phase_t phase_after(phase_t ph, logic [7:0] fl, logic hid,
                                           logic pay_nz);
        phase_t r;
        r = PH_IDLE;
        case (ph)
            PH_C_NAME:   r = PH_C_VER;
            PH_C_VER:    r = PH_C_FLAGS;
            PH_C_FLAGS:  r = PH_C_KEEP;
            PH_C_KEEP:   r = PH_C_ID_LEN;
            PH_C_ID:     r = fl[2] ? PH_C_WT_LEN :
                             fl[7] ? PH_C_USER_LEN :
                             fl[6] ? PH_C_PASS_LEN : PH_IDLE;
            PH_C_WT:     r = PH_C_WM_LEN;
            PH_C_WM:     r = fl[7] ? PH_C_USER_LEN :
                             fl[6] ? PH_C_PASS_LEN : PH_IDLE;
            PH_C_USER:   r = fl[6] ? PH_C_PASS_LEN : PH_IDLE;
            PH_CA_FLAGS: r = PH_CA_RC;
            PH_P_TOPIC:  r = hid ? PH_P_ID : (pay_nz ? PH_P_PAY : PH_IDLE);
            PH_P_ID:     r = pay_nz ? PH_P_PAY : PH_IDLE;
            PH_S_ID:     r = PH_S_TOPIC_LEN;
            PH_S_TOPIC:  r = PH_S_QOS;
            default:     r = PH_IDLE;
        endcase
        return r;
    endfunction

    // string body that a length prefix introduces
    function automatic phase_t body_of(phase_t ph);
        phase_t r;
        r = PH_IDLE;
        case (ph)
            PH_C_NAME_LEN:  r = PH_C_NAME;
            PH_C_ID_LEN:    r = PH_C_ID;
            PH_C_WT_LEN:    r = PH_C_WT;
            PH_C_WM_LEN:    r = PH_C_WM;
            PH_C_USER_LEN:  r = PH_C_USER;
            PH_C_PASS_LEN:  r = PH_C_PASS;
            PH_P_TOPIC_LEN: r = PH_P_TOPIC;
            PH_S_TOPIC_LEN: r = PH_S_TOPIC;
            default:        r = PH_IDLE;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] field_of(phase_t ph);
        logic [4:0] r;
        r = FC_HEADER;
        case (ph)
            PH_C_NAME_LEN, PH_C_NAME:   r = FC_C_NAME;
            PH_C_VER:                   r = FC_C_VER;
            PH_C_FLAGS:                 r = FC_C_FLAGS;
            PH_C_KEEP:                  r = FC_C_KEEP;
            PH_C_ID_LEN, PH_C_ID:       r = FC_C_ID;
            PH_C_WT_LEN, PH_C_WT:       r = FC_C_WTOPIC;
            PH_C_WM_LEN, PH_C_WM:       r = FC_C_WMSG;
            PH_C_USER_LEN, PH_C_USER:   r = FC_C_USER;
            PH_C_PASS_LEN, PH_C_PASS:   r = FC_C_PASS;
            PH_CA_FLAGS:                r = FC_CA_FLAGS;
            PH_CA_RC:                   r = FC_CA_RC;
            PH_P_TOPIC_LEN, PH_P_TOPIC: r = FC_P_TOPIC;
            PH_P_ID:                    r = FC_P_ID;
            PH_P_PAY:                   r = FC_P_PAY;
            PH_S_ID:                    r = FC_S_ID;
            PH_S_TOPIC_LEN, PH_S_TOPIC: r = FC_S_TOPIC;
            PH_S_QOS:                   r = FC_S_QOS;
            default:                    r = FC_HEADER;
        endcase
        return r;
    endfunction

    logic        is_prefix;
    logic        is_pair;
    logic        is_string;
    logic [15:0] len;
    logic [27:0] need;
    logic        abort;
    phase_t      nxt;

    assign item_take = item_valid && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        is_prefix = (phase_reg == PH_C_NAME_LEN) || (phase_reg == PH_C_ID_LEN) ||
                    (phase_reg == PH_C_WT_LEN) || (phase_reg == PH_C_WM_LEN) ||
                    (phase_reg == PH_C_USER_LEN) || (phase_reg == PH_C_PASS_LEN) ||
                    (phase_reg == PH_P_TOPIC_LEN) || (phase_reg == PH_S_TOPIC_LEN);
        is_pair   = is_prefix || (phase_reg == PH_C_KEEP) || (phase_reg == PH_P_ID) ||
                    (phase_reg == PH_S_ID);
        is_string = (phase_reg == PH_C_NAME) || (phase_reg == PH_C_ID) ||
                    (phase_reg == PH_C_WT) || (phase_reg == PH_C_WM) ||
                    (phase_reg == PH_C_USER) || (phase_reg == PH_C_PASS) ||
                    (phase_reg == PH_P_TOPIC) || (phase_reg == PH_S_TOPIC);
        len   = {hi_reg, item.data_byte};
        need  = {12'd0, len} + 28'd2 + (has_id_reg ? 28'd2 : 28'd0);
        abort = 1'b0;
        nxt   = phase_reg;

        phase_next  = phase_reg;
        flags_next  = flags_reg;
        has_id_next = has_id_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        fleft_next  = fleft_reg;
        pay_next    = pay_reg;
        res_next    = '0;

        if (item.req_type == REQ_HEADER) begin
            // a header always restarts, dropping any packet in progress
            has_id_next = (item.qos_level == 2'd1) || (item.qos_level == 2'd2);
            pay_next    = item.rem_len;
            flags_next  = 8'd0;
            idx_next    = 1'b0;
            hi_next     = 8'd0;
            fleft_next  = 16'd0;
            case (item.packet_type)
                PT_CONNECT:   phase_next = PH_C_NAME_LEN;
                PT_CONNACK:   phase_next = PH_CA_FLAGS;
                PT_PUBLISH:   phase_next = PH_P_TOPIC_LEN;
                PT_SUBSCRIBE: phase_next = PH_S_ID;
                PT_PINGREQ, PT_DISCONNECT: begin
                    phase_next           = PH_IDLE;
                    res_next.packet_done = 1'b1;
                end
                default: begin
                    phase_next      = PH_IDLE;
                    res_next.status = ST_UNSUPPORTED;
                end
            endcase
        end else if (phase_reg == PH_IDLE) begin
            res_next.byte_value = item.data_byte;
            res_next.status     = ST_STRAY;
        end else begin
            res_next.field_code = field_of(phase_reg);
            res_next.byte_value = item.data_byte;
            if (is_pair) begin
                res_next.is_length_byte = is_prefix;
                if (!idx_reg) begin
                    hi_next             = item.data_byte;
                    idx_next            = 1'b1;
                    res_next.word_value = {item.data_byte, 8'd0};
                end else begin
                    hi_next             = item.data_byte;
                    idx_next            = 1'b0;
                    res_next.word_value = len;
                    if (phase_reg == PH_P_TOPIC_LEN) begin
                        if (pay_reg < need) begin
                            abort           = 1'b1;
                            res_next.status = ST_NEG_PAYLOAD;
                            nxt             = PH_IDLE;
                        end else begin
                            pay_next = pay_reg - need;
                        end
                    end
                    if (!abort) begin
                        if (!is_prefix) begin
                            res_next.field_last = 1'b1;
                            nxt = phase_after(phase_reg, flags_reg, has_id_reg,
                                              pay_next != 28'd0);
                        end else if (len != 16'd0) begin
                            fleft_next = len;
                            nxt        = body_of(phase_reg);
                        end else begin
                            // empty string ends on its second length byte
                            res_next.field_last = 1'b1;
                            nxt = phase_after(body_of(phase_reg), flags_reg, has_id_reg,
                                              pay_next != 28'd0);
                        end
                    end
                end
            end else if (phase_reg == PH_P_PAY) begin
                pay_next = pay_reg - {27'd0, (pay_reg != 28'd0)};
                if (pay_next == 28'd0) begin
                    res_next.field_last = 1'b1;
                    nxt                 = PH_IDLE;
                end
            end else if (is_string) begin
                fleft_next = fleft_reg - {15'd0, (fleft_reg != 16'd0)};
                if (fleft_next == 16'd0) begin
                    res_next.field_last = 1'b1;
                    nxt = phase_after(phase_reg, flags_reg, has_id_reg, pay_reg != 28'd0);
                end
            end else begin
                if (phase_reg == PH_C_FLAGS) begin
                    flags_next          = item.data_byte;
                    // will qos sits in bits 4:3 of the flags byte
                    res_next.word_value = {9'd0, item.data_byte[7], item.data_byte[6],
                                           item.data_byte[5], item.data_byte[4:3],
                                           item.data_byte[2], item.data_byte[1]};
                end
                res_next.field_last = 1'b1;
                nxt = phase_after(phase_reg, flags_next, has_id_reg, pay_reg != 28'd0);
            end
            phase_next           = nxt;
            res_next.packet_done = (nxt == PH_IDLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            flags_reg   <= 8'd0;
            has_id_reg  <= 1'b0;
            idx_reg     <= 1'b0;
            hi_reg      <= 8'd0;
            fleft_reg   <= 16'd0;
            pay_reg     <= 28'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (item_take) begin
                phase_reg   <= phase_next;
                flags_reg   <= flags_next;
                has_id_reg  <= has_id_next;
                idx_reg     <= idx_next;
                hi_reg      <= hi_next;
                fleft_reg   <= fleft_next;
                pay_reg     <= pay_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> dv/mvhp_field_checker.sv
// ----------------------------------------------------------------------------
// mvhp_field_checker
// watches both channels of the variable header parser, tracks the parse of
// every accepted request and compares each result with the predicted tag
// ----------------------------------------------------------------------------
module mvhp_field_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mvhp_pkg::mvhp_req_t s_req,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mvhp_pkg::mvhp_res_t m_res,
    output int                  fail_count,
    output int                  outstanding,
    output int                  results_seen
);
    import mvhp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    phase_t      phase;
    logic [1:0]  cur_qos;
    logic [7:0]  connect_flags;
    logic        second_byte;
    logic [15:0] word_acc;
    logic [15:0] string_left;
    logic [27:0] payload_left;

    mvhp_res_t   expected_tags[$];

    function automatic logic has_msg_id();
        return cur_qos == 2'd1 || cur_qos == 2'd2;
    endfunction

    function automatic logic [4:0] field_of(input phase_t p);
        case (p)
            PH_C_NAME_LEN, PH_C_NAME:   return FC_C_NAME;
            PH_C_VER:                   return FC_C_VER;
            PH_C_FLAGS:                 return FC_C_FLAGS;
            PH_C_KEEP:                  return FC_C_KEEP;
            PH_C_ID_LEN, PH_C_ID:       return FC_C_ID;
            PH_C_WT_LEN, PH_C_WT:       return FC_C_WTOPIC;
            PH_C_WM_LEN, PH_C_WM:       return FC_C_WMSG;
            PH_C_USER_LEN, PH_C_USER:   return FC_C_USER;
            PH_C_PASS_LEN, PH_C_PASS:   return FC_C_PASS;
            PH_CA_FLAGS:                return FC_CA_FLAGS;
            PH_CA_RC:                   return FC_CA_RC;
            PH_P_TOPIC_LEN, PH_P_TOPIC: return FC_P_TOPIC;
            PH_P_ID:                    return FC_P_ID;
            PH_P_PAY:                   return FC_P_PAY;
            PH_S_ID:                    return FC_S_ID;
            PH_S_TOPIC_LEN, PH_S_TOPIC: return FC_S_TOPIC;
            PH_S_QOS:                   return FC_S_QOS;
            default:                    return FC_HEADER;
        endcase
    endfunction

    // string body behind a length prefix, idle for anything else
    function automatic phase_t body_of(input phase_t p);
        case (p)
            PH_C_NAME_LEN:  return PH_C_NAME;
            PH_C_ID_LEN:    return PH_C_ID;
            PH_C_WT_LEN:    return PH_C_WT;
            PH_C_WM_LEN:    return PH_C_WM;
            PH_C_USER_LEN:  return PH_C_USER;
            PH_C_PASS_LEN:  return PH_C_PASS;
            PH_P_TOPIC_LEN: return PH_P_TOPIC;
            PH_S_TOPIC_LEN: return PH_S_TOPIC;
            default:        return PH_IDLE;
        endcase
    endfunction

    function automatic logic is_string_body(input phase_t p);
        case (p)
            PH_C_NAME, PH_C_ID, PH_C_WT, PH_C_WM, PH_C_USER, PH_C_PASS,
            PH_P_TOPIC, PH_S_TOPIC: return 1'b1;
            default:                return 1'b0;
        endcase
    endfunction

    // next phase once a field is complete, absent optional fields skipped
    function automatic phase_t after_field(input phase_t p);
        case (p)
            PH_C_NAME:   return PH_C_VER;
            PH_C_VER:    return PH_C_FLAGS;
            PH_C_FLAGS:  return PH_C_KEEP;
            PH_C_KEEP:   return PH_C_ID_LEN;
            PH_C_ID: begin
                if (connect_flags[2]) return PH_C_WT_LEN;
                if (connect_flags[7]) return PH_C_USER_LEN;
                if (connect_flags[6]) return PH_C_PASS_LEN;
                return PH_IDLE;
            end
            PH_C_WT:     return PH_C_WM_LEN;
            PH_C_WM: begin
                if (connect_flags[7]) return PH_C_USER_LEN;
                if (connect_flags[6]) return PH_C_PASS_LEN;
                return PH_IDLE;
            end
            PH_C_USER:   return connect_flags[6] ? PH_C_PASS_LEN : PH_IDLE;
            PH_CA_FLAGS: return PH_CA_RC;
            PH_P_TOPIC: begin
                if (has_msg_id()) return PH_P_ID;
                return (payload_left != 28'd0) ? PH_P_PAY : PH_IDLE;
            end
            PH_P_ID:     return (payload_left != 28'd0) ? PH_P_PAY : PH_IDLE;
            PH_S_ID:     return PH_S_TOPIC_LEN;
            PH_S_TOPIC:  return PH_S_QOS;
            default:     return PH_IDLE;
        endcase
    endfunction

    // advances the parse by one request and returns the tag it should get
    function automatic mvhp_res_t tag_request(input mvhp_req_t r);
        mvhp_res_t   e;
        phase_t      nxt;
        logic        prefix;
        logic        pair;
        logic        aborted;
        logic [28:0] need;
        e = '0;
        if (r.req_type == REQ_HEADER) begin
            cur_qos       = r.qos_level;
            payload_left  = r.rem_len;
            connect_flags = '0;
            second_byte   = 1'b0;
            word_acc      = '0;
            string_left   = '0;
            e.field_code  = FC_HEADER;
            case (r.packet_type)
                PT_CONNECT:   phase = PH_C_NAME_LEN;
                PT_CONNACK:   phase = PH_CA_FLAGS;
                PT_PUBLISH:   phase = PH_P_TOPIC_LEN;
                PT_SUBSCRIBE: phase = PH_S_ID;
                PT_PINGREQ, PT_DISCONNECT: begin
                    phase         = PH_IDLE;
                    e.packet_done = 1'b1;
                end
                default: begin
                    phase    = PH_IDLE;
                    e.status = ST_UNSUPPORTED;
                end
            endcase
        end else if (phase == PH_IDLE) begin
            e.byte_value = r.data_byte;
            e.status     = ST_STRAY;
        end else begin
            nxt          = phase;
            prefix       = body_of(phase) != PH_IDLE;
            pair         = prefix || phase == PH_C_KEEP || phase == PH_P_ID ||
                           phase == PH_S_ID;
            e.field_code = field_of(phase);
            e.byte_value = r.data_byte;
            if (pair) begin
                e.is_length_byte = prefix;
                if (!second_byte) begin
                    word_acc    = {r.data_byte, 8'h00};
                    second_byte = 1'b1;
                    e.word_value = word_acc;
                end else begin
                    word_acc     = word_acc | {8'h00, r.data_byte};
                    second_byte  = 1'b0;
                    e.word_value = word_acc;
                    aborted      = 1'b0;
                    // topic length known: the rest of the packet is payload
                    if (phase == PH_P_TOPIC_LEN) begin
                        need = 29'd2 + {13'd0, word_acc} + (has_msg_id() ? 29'd2 : 29'd0);
                        if ({1'b0, payload_left} < need) begin
                            e.status = ST_NEG_PAYLOAD;
                            aborted  = 1'b1;
                            nxt      = PH_IDLE;
                        end else begin
                            payload_left = payload_left - need[27:0];
                        end
                    end
                    if (!aborted) begin
                        if (!prefix) begin
                            e.field_last = 1'b1;
                            nxt          = after_field(phase);
                        end else if (word_acc != 16'd0) begin
                            string_left = word_acc;
                            nxt         = body_of(phase);
                        end else begin
                            e.field_last = 1'b1;
                            nxt          = after_field(body_of(phase));
                        end
                    end
                end
            end else if (phase == PH_P_PAY) begin
                if (payload_left != 28'd0) payload_left = payload_left - 28'd1;
                if (payload_left == 28'd0) begin
                    e.field_last = 1'b1;
                    nxt          = PH_IDLE;
                end
            end else if (is_string_body(phase)) begin
                if (string_left != 16'd0) string_left = string_left - 16'd1;
                if (string_left == 16'd0) begin
                    e.field_last = 1'b1;
                    nxt          = after_field(phase);
                end
            end else begin
                if (phase == PH_C_FLAGS) begin
                    connect_flags = r.data_byte;
                    e.word_value  = {9'd0, r.data_byte[7], r.data_byte[6],
                                     r.data_byte[5], r.data_byte[4:3],
                                     r.data_byte[2], r.data_byte[1]};
                end
                e.field_last = 1'b1;
                nxt          = after_field(phase);
            end
            phase = nxt;
            if (nxt == PH_IDLE) e.packet_done = 1'b1;
        end
        return e;
    endfunction

    task automatic show_tag(input string what, input mvhp_res_t v);
        $display("    %s code %0d len %0b byte %02h word %04h last %0b done %0b status %0d",
                 what, v.field_code, v.is_length_byte, v.byte_value, v.word_value,
                 v.field_last, v.packet_done, v.status);
    endtask

    always @(posedge aclk) begin : watch
        mvhp_res_t want;
        logic      wrong;
        if (!aresetn) begin
            phase         = PH_IDLE;
            cur_qos       = '0;
            connect_flags = '0;
            second_byte   = 1'b0;
            word_acc      = '0;
            string_left   = '0;
            payload_left  = '0;
            expected_tags.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_tags.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: code %0d status %0d",
                                 $time, m_res.field_code, m_res.status);
                end else begin
                    want  = expected_tags.pop_front();
                    wrong = (m_res.field_code     !== want.field_code)     ||
                            (m_res.is_length_byte !== want.is_length_byte) ||
                            (m_res.byte_value     !== want.byte_value)     ||
                            (m_res.word_value     !== want.word_value)     ||
                            (m_res.field_last     !== want.field_last)     ||
                            (m_res.packet_done    !== want.packet_done)    ||
                            (m_res.status         !== want.status);
                    if (wrong) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: result %0d mismatch", $time, results_seen);
                            show_tag("expected", want);
                            show_tag("actual  ", m_res);
                        end
                    end
                end
            end
            if (s_valid && s_ready) expected_tags.push_back(tag_request(s_req));
        end
        outstanding = expected_tags.size();
    end

endmodule

>>> dv/mqtt_variable_header_parser_tb.sv
// ----------------------------------------------------------------------------
// mqtt_variable_header_parser_tb
// streams mqtt packets, well formed, cut short and random noise, through the
// parser under four flow-control phases and lets the checker judge results
// ----------------------------------------------------------------------------
module mqtt_variable_header_parser_tb;
    import mvhp_pkg::*;

    localparam int         RANDOM_ITEMS = 1150;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam logic [3:0] PT_RESERVED  = 4'd15;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    mvhp_req_t s_req;
    logic      m_valid;
    logic      m_ready;
    mvhp_res_t m_res;

    int fail_count;
    int outstanding;
    int results_seen;
    int src_idle_pct;
    int sink_stall_pct;
    int requests_sent;
    int cycle_count;
    int connect_pkts, connack_pkts, publish_pkts, subscribe_pkts, other_pkts;

    mvhp_req_t pkt_q[$];

    mqtt_variable_header_parser DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    mvhp_field_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req        (s_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_res        (m_res),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic int pick_len();
        if ($urandom_range(29) == 0) return int'($urandom_range(300));
        return int'($urandom_range(5));
    endfunction

    task automatic add_header(input logic [3:0] ptype, input logic [1:0] qos,
                              input logic [27:0] rlen);
        mvhp_req_t r;
        r.req_type    = REQ_HEADER;
        r.data_byte   = 8'($urandom);
        r.packet_type = ptype;
        r.qos_level   = qos;
        r.rem_len     = rlen;
        pkt_q.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] b);
        mvhp_req_t r;
        r.req_type    = REQ_DATA;
        r.data_byte   = b;
        r.packet_type = 4'($urandom);
        r.qos_level   = 2'($urandom);
        r.rem_len     = 28'($urandom);
        pkt_q.push_back(r);
    endtask

    // two-byte length prefix followed by the string body
    task automatic add_string(input int len);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        repeat (len) add_byte(8'($urandom));
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input mvhp_req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic send_packet();
        foreach (pkt_q[i]) send_request(pkt_q[i]);
        pkt_q.delete();
    endtask

    task automatic send_random_packet();
        int          sel;
        int          qos;
        int          tlen;
        int          plen;
        int          need;
        int          kind;
        int          keep_n;
        logic [3:0]  rtype;
        logic [7:0]  flags;
        logic [27:0] rlen;
        mvhp_req_t   r;
        sel = int'($urandom_range(99));
        if (sel < 22) begin
            connect_pkts++;
            flags = 8'($urandom);
            add_header(PT_CONNECT, 2'($urandom), 28'($urandom));
            add_string(($urandom_range(3) == 0) ? pick_len() : 4);
            add_byte(($urandom_range(1) == 0) ? 8'h04 : 8'($urandom));
            add_byte(flags);
            add_byte(8'($urandom));
            add_byte(8'($urandom));
            add_string(pick_len());
            if (flags[2]) begin
                add_string(pick_len());
                add_string(pick_len());
            end
            if (flags[7]) add_string(pick_len());
            if (flags[6]) add_string(pick_len());
        end else if (sel < 32) begin
            connack_pkts++;
            add_header(PT_CONNACK, 2'($urandom), 28'($urandom));
            add_byte(8'($urandom));
            add_byte(8'($urandom));
        end else if (sel < 58) begin
            publish_pkts++;
            qos  = int'($urandom_range(3));
            tlen = pick_len();
            plen = int'($urandom_range(6));
            need = 2 + tlen + ((qos == 1 || qos == 2) ? 2 : 0);
            kind = int'($urandom_range(19));
            // short remaining length, or one so long the packet stays open
            if (kind < 3) rlen = 28'($urandom_range(need - 1));
            else if (kind == 3) rlen = 28'hFFFFFFF - 28'($urandom_range(1000));
            else rlen = 28'(need + plen);
            add_header(PT_PUBLISH, 2'(qos), rlen);
            add_string(tlen);
            if (qos == 1 || qos == 2) begin
                add_byte(8'($urandom));
                add_byte(8'($urandom));
            end
            repeat (plen) add_byte(8'($urandom));
        end else if (sel < 73) begin
            subscribe_pkts++;
            add_header(PT_SUBSCRIBE, 2'($urandom), 28'($urandom));
            add_byte(8'($urandom));
            add_byte(8'($urandom));
            add_string(pick_len());
            add_byte(8'($urandom));
        end else if (sel < 79) begin
            other_pkts++;
            add_header(($urandom_range(1) == 0) ? PT_PINGREQ : PT_DISCONNECT,
                       2'($urandom), 28'($urandom));
        end else if (sel < 85) begin
            other_pkts++;
            do rtype = 4'($urandom_range(15));
            while (rtype == PT_CONNECT || rtype == PT_CONNACK || rtype == PT_PUBLISH ||
                   rtype == PT_SUBSCRIBE || rtype == PT_PINGREQ ||
                   rtype == PT_DISCONNECT);
            add_header(rtype, 2'($urandom), 28'($urandom));
            repeat ($urandom_range(2)) add_byte(8'($urandom));
        end else begin
            other_pkts++;
            repeat ($urandom_range(1, 4)) begin
                r.req_type    = 1'($urandom);
                r.data_byte   = 8'($urandom);
                r.packet_type = 4'($urandom);
                r.qos_level   = 2'($urandom);
                r.rem_len     = 28'($urandom);
                pkt_q.push_back(r);
            end
        end
        // now and then the next header lands in the middle of a packet
        if (pkt_q.size() > 1 && $urandom_range(9) == 0) begin
            keep_n = int'($urandom_range(1, pkt_q.size() - 1));
            while (pkt_q.size() > keep_n) void'(pkt_q.pop_back());
        end
        send_packet();
    endtask

    initial begin
        int goal;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req          = '0;
        m_ready        = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // stray byte before any packet
        add_byte(8'hFF);
        // bodiless packets, widest remaining length
        add_header(PT_PINGREQ, 2'd3, 28'hFFFFFFF);
        add_header(PT_DISCONNECT, 2'd0, 28'd0);
        add_header(PT_RESERVED, 2'd0, 28'd0);
        // connect with every optional field present and every string empty
        add_header(PT_CONNECT, 2'd0, 28'd22);
        add_string(0);
        add_byte(8'h04);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'h3C);
        repeat (5) add_string(0);
        // publish qos 1 whose remaining length cannot hold topic and id
        add_header(PT_PUBLISH, 2'd1, 28'd3);
        add_byte(8'h00);
        add_byte(8'h01);
        // subscribe cut short by the next header
        add_header(PT_SUBSCRIBE, 2'd1, 28'd0);
        add_byte(8'h12);
        send_packet();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            goal = requests_sent + RANDOM_ITEMS / 4;
            while (requests_sent < goal) send_random_packet();
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(negedge aclk);
        sink_stall_pct = 0;
        repeat (8) @(negedge aclk);

        $display("sent %0d requests across four flow-control phases, %0d results checked",
                 requests_sent, results_seen);
        $display("packets: %0d connect, %0d connack, %0d publish, %0d subscribe, %0d other",
                 connect_pkts, connack_pkts, publish_pkts, subscribe_pkts, other_pkts);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d results failed", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
